/* rtl/core/assert_macros.svh */
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCNM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gcnm_pkg.sv */
// Shared constants and types of the greedy caliper neighbor matcher.
`timescale 1ns / 1ps

package gcnm_pkg;

  localparam int MAX_CONTROLS   = 1024;
  localparam int MAX_NEIGHBOURS = 8;
  localparam int MAX_TREATED    = 4096;

  localparam int DIST_W     = 32;
  localparam int CTRL_W     = 10;
  localparam int ROW_W      = 12;
  localparam int NW_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NB_IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int CNT_W    = $clog2(MAX_NEIGHBOURS + 1);
  localparam int ADDR_W   = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
  localparam int ROWCNT_W = (MAX_TREATED > 1) ? $clog2(MAX_TREATED) : 1;

  // Used marks are stored as job tags; tag zero is what the clearing pass writes.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = EPOCH_W'((2 ** EPOCH_W) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOW_REUSE = 2'd0,
    CFG_CALIPER_EN  = 2'd1,
    CFG_CALIPER_LIM = 2'd2,
    CFG_NEIGHBOURS  = 2'd3
  } cfg_idx_t;

endpackage

/* rtl/core/greedy_caliper_neighbour_match_unit.sv */
// Greedy nearest-neighbor matcher with caliper: top level.
// The output buffer offers a row's matches once its last request leaves the input register.
// Throughput: one distance request per cycle outside the clearing pass; a row end waits while the
// previous row's matches leave the single output buffer, one per cycle while out_ready is high.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass sweeps all 1024
// entries of the used-mark RAM; it runs again at the 255th job start and every 254th after.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module greedy_caliper_neighbour_match_unit
  import gcnm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_first_of_job,
  input  logic [DIST_W-1:0]     in_distance,
  input  logic [CTRL_W-1:0]     in_control_index,
  input  logic                  in_row_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_W-1:0]      out_treated_index,
  output logic [CTRL_W-1:0]     out_matched_control,
  output logic [DIST_W-1:0]     out_match_distance,
  output logic                  out_last_of_row
);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // Configuration registers.
  logic              allow_reuse_r;
  logic              caliper_en_r;
  logic [DIST_W-1:0] caliper_lim_r;
  logic [NW_W-1:0]   nw_r;

  // Control: clearing pass and job tag.
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_ptr_r, clr_ptr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;

  // Input register; the used-mark read for the same request lands alongside it.
  logic              s1_valid_r;
  logic              s1_first_r;
  logic [DIST_W-1:0] s1_dist_r;
  logic [CTRL_W-1:0] s1_ctrl_r;
  logic              s1_last_r;
  logic              s1_hit_r;

  // Sorted candidate list of the row being built.
  logic [DIST_W-1:0] best_d_r [MAX_NEIGHBOURS];
  logic [CTRL_W-1:0] best_c_r [MAX_NEIGHBOURS];
  logic [CNT_W-1:0]  best_cnt_r;
  logic [DIST_W-1:0] best_d_nxt [MAX_NEIGHBOURS];
  logic [CTRL_W-1:0] best_c_nxt [MAX_NEIGHBOURS];

  logic [ROWCNT_W-1:0] row_cnt_r;

  // Output buffer: one finished row, drained one match per cycle while out_ready is high.
  logic                bank_valid_r;
  logic [DIST_W-1:0]   bank_d_r [MAX_NEIGHBOURS];
  logic [CTRL_W-1:0]   bank_c_r [MAX_NEIGHBOURS];
  logic [CNT_W-1:0]    bank_cnt_r;
  logic [NB_IDX_W-1:0] bank_ptr_r;
  logic [ROWCNT_W-1:0] bank_row_r;
  logic [EPOCH_W-1:0]  bank_epoch_r;

  // Used-mark RAM ports.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] ram_rdata;

  logic                    in_fire, s1_fire, out_fire;
  logic [CNT_W-1:0]        lim, cnt0, cnt1, cnt_new;
  logic [NB_IDX_W-1:0]     lim_m1;
  logic [MAX_NEIGHBOURS-1:0] lt;
  logic                    pend, wr_hit_now, wr_hit_in, used, ok, ins;
  logic                    epoch_wrap;
  logic [ROWCNT_W-1:0]     row_base;

  // ---------------------------------------------------------------------------
  // Configuration writes. The user must write them only while the block is idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_reuse_r <= 1'b0;
      caliper_en_r  <= 1'b0;
      caliper_lim_r <= '1;
      nw_r          <= NW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALLOW_REUSE: allow_reuse_r <= cfg_wdata[0];
        CFG_CALIPER_EN:  caliper_en_r  <= cfg_wdata[0];
        CFG_CALIPER_LIM: caliper_lim_r <= cfg_wdata[DIST_W-1:0];
        CFG_NEIGHBOURS:  nw_r          <= cfg_wdata[NW_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Candidate list update for the request held in the input register.
  // ---------------------------------------------------------------------------

  // Neighbor count: zero acts as one, large counts saturate.
  always_comb begin
    if (nw_r == '0) begin
      lim = CNT_W'(1);
    end else if (32'(nw_r) > MAX_NEIGHBOURS) begin
      lim = CNT_W'(MAX_NEIGHBOURS);
    end else begin
      lim = CNT_W'(nw_r);
    end
  end
  assign lim_m1 = NB_IDX_W'(lim - CNT_W'(1));

  // A job start discards the partial list; a lowered count cuts the list.
  assign cnt0 = s1_first_r ? '0 : best_cnt_r;
  assign cnt1 = (cnt0 > lim) ? lim : cnt0;

  // A control is used when its mark is in the RAM for this job, was written
  // after the read was issued, is being written now, or still waits in the
  // output buffer. A job start clears every mark before its own request.
  always_comb begin
    pend = 1'b0;
    for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
      if (bank_valid_r && (CNT_W'(k) >= CNT_W'(bank_ptr_r)) && (CNT_W'(k) < bank_cnt_r) &&
          (bank_c_r[k] == s1_ctrl_r) && (bank_epoch_r == epoch_r)) begin
        pend = 1'b1;
      end
    end
  end
  assign wr_hit_now = ram_we && (ram_waddr == ADDR_W'(s1_ctrl_r)) && (ram_wdata == epoch_r);
  assign used = !s1_first_r && ((ram_rdata == epoch_r) || s1_hit_r || wr_hit_now || pend);

  assign ok = (32'(s1_ctrl_r) < MAX_CONTROLS) &&
              !(caliper_en_r && (s1_dist_r > caliper_lim_r)) &&
              (allow_reuse_r || !used);

  // Entries that stay ahead of the new distance; the list is sorted, so these
  // form a prefix. Equal distances stay ahead, which keeps arrival order.
  always_comb begin
    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      lt[i] = (CNT_W'(i) < cnt1) && (best_d_r[i] <= s1_dist_r);
    end
  end

  // The new distance only goes in if it lands within the neighbor count.
  assign ins = ok && !lt[lim_m1];

  // Parallel insert: keep the prefix, place the new entry, shift the rest down.
  always_comb begin
    best_d_nxt[0] = best_d_r[0];
    best_c_nxt[0] = best_c_r[0];
    if (ins && !lt[0]) begin
      best_d_nxt[0] = s1_dist_r;
      best_c_nxt[0] = s1_ctrl_r;
    end
    for (int j = 1; j < MAX_NEIGHBOURS; j++) begin
      best_d_nxt[j] = best_d_r[j];
      best_c_nxt[j] = best_c_r[j];
      if (ins && !lt[j]) begin
        if (lt[j-1]) begin
          best_d_nxt[j] = s1_dist_r;
          best_c_nxt[j] = s1_ctrl_r;
        end else begin
          best_d_nxt[j] = best_d_r[j-1];
          best_c_nxt[j] = best_c_r[j-1];
        end
      end
    end
  end

  assign cnt_new = ins ? ((cnt1 < lim) ? (cnt1 + CNT_W'(1)) : lim) : cnt1;

  // The job tag wraps at its top value: the request that starts that job waits
  // for a fresh clearing pass before it goes through.
  assign epoch_wrap = s1_first_r && (epoch_r == EPOCH_MAX);

  // A row end needs the output buffer free unless the row yields no match.
  assign s1_fire = (state_r == ST_RUN) && s1_valid_r && !epoch_wrap &&
                   (!s1_last_r || !bank_valid_r || (cnt_new == '0));
  assign in_ready = (state_r == ST_RUN) && (!s1_valid_r || s1_fire);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign row_base = s1_first_r ? '0 : row_cnt_r;

  // ---------------------------------------------------------------------------
  // Control: clearing pass and job tag.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    epoch_nxt   = epoch_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_ptr_nxt = clr_ptr_r + ADDR_W'(1);
        if (clr_ptr_r == ADDR_W'(MAX_CONTROLS - 1)) begin
          state_nxt = ST_RUN;
          epoch_nxt = EPOCH_W'(1);
        end
      end
      ST_RUN: begin
        if (s1_valid_r && epoch_wrap && !bank_valid_r) begin
          state_nxt   = ST_CLEAR;
          clr_ptr_nxt = '0;
        end else if (s1_fire && s1_first_r) begin
          epoch_nxt = epoch_r + EPOCH_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_ptr_r <= '0;
      epoch_r   <= EPOCH_W'(1);
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      epoch_r   <= epoch_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The hit flag catches mark writes that land after the RAM
  // read of this request was issued.
  // ---------------------------------------------------------------------------
  assign wr_hit_in = ram_we && (ram_waddr == ADDR_W'(in_control_index)) &&
                     (ram_wdata == epoch_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first_r <= in_first_of_job;
      s1_dist_r  <= in_distance;
      s1_ctrl_r  <= in_control_index;
      s1_last_r  <= in_row_last;
      s1_hit_r   <= wr_hit_in;
    end else if (s1_valid_r) begin
      s1_hit_r   <= s1_hit_r || (ram_we && (ram_waddr == ADDR_W'(s1_ctrl_r)) &&
                                 (ram_wdata == epoch_nxt));
    end
  end

  // ---------------------------------------------------------------------------
  // Candidate list and row counter.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_cnt_r <= '0;
      row_cnt_r  <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        best_cnt_r <= '0;
        // The counter saturates at the last treated row.
        row_cnt_r  <= (32'(row_base) < MAX_TREATED - 1) ? (row_base + ROWCNT_W'(1)) : row_base;
      end else begin
        best_cnt_r <= cnt_new;
        row_cnt_r  <= row_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
        best_d_r[i] <= best_d_nxt[i];
        best_c_r[i] <= best_c_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer. A row end with at least one match loads it; the matches
  // leave nearest first, and each one marks its control while reuse is off.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_valid_r <= 1'b0;
      bank_ptr_r   <= '0;
    end else if (s1_fire && s1_last_r && (cnt_new != '0)) begin
      bank_valid_r <= 1'b1;
      bank_ptr_r   <= '0;
    end else if (out_fire) begin
      if (out_last_of_row) begin
        bank_valid_r <= 1'b0;
      end else begin
        bank_ptr_r   <= bank_ptr_r + NB_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r && (cnt_new != '0)) begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
        bank_d_r[i] <= best_d_nxt[i];
        bank_c_r[i] <= best_c_nxt[i];
      end
      bank_cnt_r   <= cnt_new;
      bank_row_r   <= row_base;
      bank_epoch_r <= epoch_nxt;
    end
  end

  assign out_valid           = bank_valid_r;
  assign out_treated_index   = ROW_W'(bank_row_r);
  assign out_matched_control = bank_c_r[bank_ptr_r];
  assign out_match_distance  = bank_d_r[bank_ptr_r];
  assign out_last_of_row     = ((CNT_W'(bank_ptr_r) + CNT_W'(1)) == bank_cnt_r);

  // ---------------------------------------------------------------------------
  // Used-mark RAM: the clearing pass and the mark writes never overlap, since
  // the pass only starts with the output buffer empty.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_ptr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = out_fire && !allow_reuse_r;
      ram_waddr = ADDR_W'(bank_c_r[bank_ptr_r]);
      ram_wdata = bank_epoch_r;
    end
  end

  gcnm_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (MAX_CONTROLS)
  ) u_used_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ADDR_W'(in_control_index)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `GCNM_ASSERT_SAME(a_clear_empty, state_r == ST_CLEAR, !out_valid, "matches pending in clear")
  `GCNM_ASSERT_SAME(a_epoch_nonzero, state_r == ST_RUN, epoch_r != '0, "job tag zero in run")
  `GCNM_ASSERT_NEXT(a_row_drains, out_fire && out_last_of_row, !out_valid, "reload at row end")
  `GCNM_ASSERT_NEXT(a_nearest_first, out_fire && !out_last_of_row,
                    out_match_distance >= $past(out_match_distance), "matches out of order")

endmodule

/* rtl/core/gcnm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gcnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
